[hdl/kruskal_edge_classifier_unit_assert.svh]
// Assertion macros shared by the edge classifier modules.
`ifndef KRUSKAL_EDGE_CLASSIFIER_UNIT_ASSERT_SVH
`define KRUSKAL_EDGE_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define KEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kec assertion failed");

// Next-cycle implication, disabled while reset is active.
`define KEC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kec assertion failed");

`endif

[hdl/kec_pkg.sv]
// Types and constants shared by the edge classifier modules.
package kec_pkg;

  localparam int unsigned VERTEX_W    = 10;
  localparam int unsigned RANK_W      = 4;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 8;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  localparam logic EDGE_FOREST = 1'b0;
  localparam logic EDGE_CYCLE  = 1'b1;

  // One queued edge, after the range check.
  typedef struct packed {
    logic                in_range;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } edge_cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND_A,
    ST_FIND_B,
    ST_LINK,
    ST_BUMP,
    ST_RESULT
  } seq_state_e;

endpackage

[hdl/kec_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module kec_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/kec_front.sv]
// Input side: accept edges, check vertex range, queue them for the sequencer.
`include "kruskal_edge_classifier_unit_assert.svh"

module kec_front #(
  parameter int unsigned NUM_VERTICES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [kec_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                      clear_busy_i,
  output logic                      cmd_valid_o,
  output kec_pkg::edge_cmd_t        cmd_o,
  input  logic                      cmd_pop_i
);

  localparam int unsigned QDEPTH = 2;

  kec_pkg::edge_cmd_t queue_q [QDEPTH];
  logic               wr_ptr_q, wr_ptr_d;
  logic               rd_ptr_q, rd_ptr_d;
  logic [1:0]         count_q, count_d;
  logic               push;
  logic               full;
  kec_pkg::edge_cmd_t new_cmd;

  assign full            = (count_q == 2'(QDEPTH));
  assign s_axis_tready_o = !full && !clear_busy_i;
  assign push            = s_axis_tvalid_i && s_axis_tready_o;

  // Classify: an endpoint past the vertex count makes the edge a no-op.
  always_comb begin
    new_cmd.vertex_a = s_axis_tdata_i[kec_pkg::VERTEX_W-1:0];
    new_cmd.vertex_b = s_axis_tdata_i[2*kec_pkg::VERTEX_W-1:kec_pkg::VERTEX_W];
    new_cmd.in_range = (32'(new_cmd.vertex_a) < 32'(NUM_VERTICES)) &&
                       (32'(new_cmd.vertex_b) < 32'(NUM_VERTICES));
  end

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= new_cmd;
    end
  end

  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  `KEC_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, cmd_pop_i, cmd_valid_o)
  `KEC_ASSERT_IMP(a_no_push_clear, clk_i, rst_ni, clear_busy_i, !push)

endmodule

[hdl/kec_back.sv]
// Sequencer: clear the parent store, walk both roots, link by rank, hold the result.
`include "kruskal_edge_classifier_unit_assert.svh"

module kec_back #(
  parameter int unsigned NUM_VERTICES = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  output logic                       clear_busy_o,
  input  logic                       cmd_valid_i,
  input  kec_pkg::edge_cmd_t         cmd_i,
  output logic                       cmd_pop_o,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [kec_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned VW      = $clog2(NUM_VERTICES);
  localparam int unsigned ENTRY_W = VW + kec_pkg::RANK_W;
  localparam logic [VW-1:0] LAST_VERTEX = VW'(NUM_VERTICES - 1);

  kec_pkg::seq_state_e state_q, state_d;

  logic [VW-1:0]               clr_cnt_q, clr_cnt_d;
  logic [VW-1:0]               cur_q, cur_d;
  logic [VW-1:0]               vb_q, vb_d;
  logic [VW-1:0]               root_a_q, root_a_d;
  logic [VW-1:0]               root_b_q, root_b_d;
  logic [kec_pkg::RANK_W-1:0]  rank_a_q, rank_a_d;
  logic [kec_pkg::RANK_W-1:0]  rank_b_q, rank_b_d;
  logic                        class_q, class_d;
  logic                        out_valid_q, out_valid_d;
  logic                        out_class_q, out_class_d;
  logic                        load_out;

  logic                        ram_we;
  logic [VW-1:0]               ram_waddr;
  logic [ENTRY_W-1:0]          ram_wdata;
  logic [VW-1:0]               ram_raddr;
  logic [ENTRY_W-1:0]          ram_rdata;
  logic [VW-1:0]               rd_par;
  logic [kec_pkg::RANK_W-1:0]  rd_rank;
  logic [31:0]                 va_w, vb_w;
  logic                        at_root;
  logic                        out_free;

  assign rd_par   = ram_rdata[VW-1:0];
  assign rd_rank  = ram_rdata[ENTRY_W-1:VW];
  assign at_root  = (rd_par == cur_q);
  assign va_w     = 32'(cmd_i.vertex_a);
  assign vb_w     = 32'(cmd_i.vertex_b);
  assign out_free = !out_valid_q || m_axis_tready_i;

  kec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_VERTICES)
  ) u_parent_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kec_pkg::ST_CLEAR: begin
        if (clr_cnt_q == LAST_VERTEX) state_d = kec_pkg::ST_IDLE;
      end
      kec_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = cmd_i.in_range ? kec_pkg::ST_FIND_A : kec_pkg::ST_RESULT;
        end
      end
      kec_pkg::ST_FIND_A: begin
        if (at_root) state_d = kec_pkg::ST_FIND_B;
      end
      kec_pkg::ST_FIND_B: begin
        if (at_root) begin
          state_d = (cur_q == root_a_q) ? kec_pkg::ST_RESULT : kec_pkg::ST_LINK;
        end
      end
      kec_pkg::ST_LINK: begin
        state_d = ((rank_a_q == rank_b_q) && (rank_a_q != kec_pkg::RANK_MAX)) ?
                  kec_pkg::ST_BUMP : kec_pkg::ST_RESULT;
      end
      kec_pkg::ST_BUMP: begin
        state_d = kec_pkg::ST_RESULT;
      end
      kec_pkg::ST_RESULT: begin
        if (out_free) state_d = kec_pkg::ST_IDLE;
      end
      default: begin
        state_d = kec_pkg::ST_CLEAR;
      end
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    cur_d     = cur_q;
    vb_d      = vb_q;
    root_a_d  = root_a_q;
    root_b_d  = root_b_q;
    rank_a_d  = rank_a_q;
    rank_b_d  = rank_b_q;
    class_d   = class_q;
    cmd_pop_o = 1'b0;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = {{kec_pkg::RANK_W{1'b0}}, clr_cnt_q};
    ram_raddr = cur_q;
    case (state_q)
      kec_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      kec_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          class_d   = kec_pkg::EDGE_CYCLE;
          cur_d     = va_w[VW-1:0];
          vb_d      = vb_w[VW-1:0];
          ram_raddr = va_w[VW-1:0];
        end
      end
      kec_pkg::ST_FIND_A: begin
        if (at_root) begin
          root_a_d  = cur_q;
          rank_a_d  = rd_rank;
          cur_d     = vb_q;
          ram_raddr = vb_q;
        end else begin
          cur_d     = rd_par;
          ram_raddr = rd_par;
        end
      end
      kec_pkg::ST_FIND_B: begin
        if (at_root) begin
          root_b_d = cur_q;
          rank_b_d = rd_rank;
        end else begin
          cur_d     = rd_par;
          ram_raddr = rd_par;
        end
      end
      kec_pkg::ST_LINK: begin
        ram_we  = 1'b1;
        class_d = kec_pkg::EDGE_FOREST;
        if (rank_a_q < rank_b_q) begin
          ram_waddr = root_a_q;
          ram_wdata = {rank_a_q, root_b_q};
        end else begin
          ram_waddr = root_b_q;
          ram_wdata = {rank_b_q, root_a_q};
        end
      end
      kec_pkg::ST_BUMP: begin
        ram_we    = 1'b1;
        ram_waddr = root_a_q;
        ram_wdata = {rank_a_q + 1'b1, root_a_q};
      end
      kec_pkg::ST_RESULT: begin
        load_out = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_class_d = out_class_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_class_d = class_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kec_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    vb_q        <= vb_d;
    root_a_q    <= root_a_d;
    root_b_q    <= root_b_d;
    rank_a_q    <= rank_a_d;
    rank_b_q    <= rank_b_d;
    class_q     <= class_d;
    out_class_q <= out_class_d;
  end

  assign clear_busy_o    = (state_q == kec_pkg::ST_CLEAR);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(kec_pkg::OUT_TDATA_W-1){1'b0}}, out_class_q};

  `KEC_ASSERT_IMP(a_no_write_in_walk, clk_i, rst_ni,
    (state_q == kec_pkg::ST_FIND_A) || (state_q == kec_pkg::ST_FIND_B), !ram_we)
  `KEC_ASSERT_IMP(a_link_distinct, clk_i, rst_ni,
    state_q == kec_pkg::ST_LINK, root_a_q != root_b_q)
  `KEC_ASSERT_NXT(a_result_loaded, clk_i, rst_ni,
    load_out, out_valid_q && (out_class_q == $past(class_q)))

endmodule

[hdl/kruskal_edge_classifier_unit.sv]
// Top level of the Kruskal edge classifier: input queue, union-find sequencer, parent store.
//
// Edges arrive in weight order on the slave stream. Each edge produces exactly one item on
// the master stream. The item is 0 when the edge joins two trees of the spanning forest. It
// is 1 for a cycle edge whose ends already share a root, a self loop, or an edge with an
// endpoint not below NUM_VERTICES, which is dropped without touching state. The union-find
// store lives in one RAM of NUM_VERTICES rows. Each row holds a parent link and a 4-bit rank
// that saturates at 15. After reset the block sweeps the RAM so that every vertex is its own
// root with rank zero, and s_axis_tready_o stays low for that sweep. In the sequencer, an
// edge walks from endpoint a to its root, then from endpoint b to its root. A forest edge
// then writes the link, plus a rank bump when two equal ranks below 15 are merged. A cycle
// edge goes from the walks to the result, and an out-of-range edge skips the walks. Under
// union by rank, each endpoint has at most about log2 of NUM_VERTICES parent links above it.
// The single read port of the parent RAM serves one link of the walk per cycle. A two-entry
// queue lets the input side keep accepting while the sequencer walks. The result sits in an
// output register, so the next edge can start while it waits to be taken.
module kruskal_edge_classifier_unit #(
  parameter int unsigned NUM_VERTICES = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [9:0] vertex_a, [19:10] vertex_b, [23:20] zero
  input  logic [kec_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [0] edge_class, [7:1] zero
  output logic [kec_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic               clear_busy;
  logic               cmd_valid;
  logic               cmd_pop;
  kec_pkg::edge_cmd_t cmd;

  // Front: take items, flag out-of-range endpoints, buffer them.
  kec_front #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .clear_busy_i    (clear_busy),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  // Back: walk both roots, link by rank, register the class.
  kec_back #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_busy_o    (clear_busy),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
